// ===== hw/rtl/fdep_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry parser package
// Shared transaction types, entry byte codes and sequencer states.
// ----------------------------------------------------------------------------
package fdep_pkg;

  localparam int SLOT_CHARS = 13;
  localparam int SLOT_BITS  = SLOT_CHARS * 8;
  localparam int ENTRY_BITS = 256;

  localparam logic [7:0] MARK_END     = 8'h00;
  localparam logic [7:0] MARK_DELETED = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam logic [7:0] ATTR_DIR     = 8'h10;
  localparam logic [7:0] ATTR_ARCH    = 8'h20;
  localparam logic [7:0] ORDER_MASK   = 8'h1F;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;

  localparam logic [31:0] CLUSTER_ROOT = 32'd2;

  // Byte offsets of the long-name characters inside an entry.
  localparam int NAME_POS [SLOT_CHARS] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } fdep_state_t;

  typedef struct packed {
    logic        start_of_dir;
    logic [63:0] entry_word0;
    logic [63:0] entry_word1;
    logic [63:0] entry_word2;
    logic [63:0] entry_word3;
  } fdep_in_t;

  typedef struct packed {
    logic [63:0] chunk_low;
    logic [39:0] chunk_high;
    logic [3:0]  chunk_length;
    logic        is_directory;
    logic [31:0] start_cluster;
    logic [31:0] size_bytes;
    logic        end_of_directory;
    logic        last_of_run;
  } fdep_out_t;

endpackage

// ===== hw/rtl/fdep_sfn.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry parser: short name builder
// Forms the trimmed 8.3 name of an entry as a 13-character chunk.
// ----------------------------------------------------------------------------
module fdep_sfn (
  input  logic [fdep_pkg::ENTRY_BITS-1:0] entry,
  output logic [fdep_pkg::SLOT_BITS-1:0]  chars
);
  import fdep_pkg::*;

  logic [3:0] nlen;
  logic [1:0] elen;
  logic [1:0] k;

  always_comb begin
    nlen = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (entry[8*i +: 8] == 8'h00) begin
        nlen = 4'(i);
      end
    end
    if (nlen == 4'd8) begin
      nlen = 4'd0;
      for (int i = 0; i < 8; i++) begin
        if (entry[8*i +: 8] != CHAR_SPACE) begin
          nlen = 4'(i + 1);
        end
      end
    end
  end

  always_comb begin
    logic found;
    found = 1'b0;
    elen  = 2'd3;
    for (int i = 0; i < 3; i++) begin
      if (!found && entry[8*(8+i) +: 8] == 8'h00) begin
        found = 1'b1;
        elen  = 2'(i);
      end
    end
    if (!found) begin
      elen = 2'd0;
      for (int i = 0; i < 3; i++) begin
        if (entry[8*(8+i) +: 8] != CHAR_SPACE) begin
          elen = 2'(i + 1);
        end
      end
    end
  end

  always_comb begin
    chars = '0;
    k     = '0;
    for (int i = 0; i < SLOT_CHARS; i++) begin
      k = 2'(4'(i) - nlen - 4'd1);
      if (4'(i) < nlen) begin
        chars[8*i +: 8] = entry[8*i +: 8];
      end else if (elen != 2'd0 && 4'(i) == nlen) begin
        chars[8*i +: 8] = CHAR_DOT;
      end else if (elen != 2'd0 && 4'(i) > nlen && 4'(i) <= nlen + 4'(elen)) begin
        chars[8*i +: 8] = entry[8*(8 + int'(k)) +: 8];
      end
    end
  end

endmodule

// ===== hw/rtl/fat_directory_entry_parser.sv =====
// ----------------------------------------------------------------------------
// FAT directory entry parser
// Decodes 32-byte directory entries, keeps long-name pieces in a slot memory
// and reports each directory or archive entry's name as a run of name chunks.
// ----------------------------------------------------------------------------
//  Channel  Ports                          Moves
//  input    in_valid  in_stall  in_data    one directory entry per transaction
//  output   out_valid out_stall out_data   one name chunk or end marker
//
//  An end marker or short-name result of a taken entry sits in the output
//  register at the next edge. A long-name run reads each stored slot through
//  the registered slot memory port (ST_READ), then emits it as a chunk (ST_EMIT).
//  No entry is taken while a run is in progress or the output register is
//  full and stalled. Synchronous reset clears the state machine, the slot
//  valid bits and the end flag; the slot memory itself is not cleared.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser #(
  parameter int NAME_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fdep_pkg::fdep_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fdep_pkg::fdep_out_t out_data
);
  import fdep_pkg::*;

  localparam int SW = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;

  function automatic fdep_out_t make_chunk(input logic [SLOT_BITS-1:0] ch);
    fdep_out_t            r;
    logic [SLOT_BITS-1:0] m;
    logic                 hit;
    logic [3:0]           n;
    r   = '0;
    m   = '0;
    hit = 1'b0;
    n   = '0;
    for (int i = 0; i < SLOT_CHARS; i++) begin
      if (ch[8*i +: 8] == 8'h00) begin
        hit = 1'b1;
      end
      if (!hit) begin
        m[8*i +: 8] = ch[8*i +: 8];
        n           = n + 4'd1;
      end
    end
    r.chunk_low    = m[63:0];
    r.chunk_high   = m[103:64];
    r.chunk_length = n;
    return r;
  endfunction

  fdep_state_t             state_r, state_nxt;
  logic [NAME_SLOTS-1:0]   slot_valid_r, slot_valid_nxt;
  logic                    ended_r, ended_nxt;
  logic [NAME_SLOTS-1:0]   pend_r, pend_nxt;
  logic [NAME_SLOTS-1:0]   pend_clr;
  logic                    last_r, last_nxt;
  logic                    isdir_r, isdir_nxt;
  logic [31:0]             clus_r, clus_nxt;
  logic [31:0]             size_r, size_nxt;
  logic                    out_valid_r, out_valid_nxt;
  fdep_out_t               out_data_r, out_data_nxt;

  logic [SLOT_BITS-1:0]    mem [NAME_SLOTS];
  logic [SLOT_BITS-1:0]    rd_data_r;
  logic                    mem_we;
  logic                    rd_en;
  logic [SW-1:0]           rd_addr;
  logic [SW-1:0]           wr_addr;

  logic [ENTRY_BITS-1:0]   entry;
  logic [7:0]              first;
  logic [7:0]              attr;
  logic [7:0]              order;
  logic                    slot_ok;
  logic [SLOT_BITS-1:0]    lfn_chars;
  logic [SLOT_BITS-1:0]    sfn_chars;
  logic [31:0]             clus_raw;
  logic [31:0]             entry_clus;
  logic [31:0]             entry_size;
  logic                    entry_isdir;
  logic [NAME_SLOTS-1:0]   sv_eff;
  logic                    ended_eff;
  logic                    accept;
  logic                    out_free;
  logic                    load;
  fdep_out_t               ld;

  assign entry = {in_data.entry_word3, in_data.entry_word2,
                  in_data.entry_word1, in_data.entry_word0};
  assign first       = entry[7:0];
  assign attr        = entry[95:88];
  assign order       = first & ORDER_MASK;
  assign slot_ok     = order < 8'(NAME_SLOTS);
  assign wr_addr     = order[SW-1:0];
  assign clus_raw    = {entry[175:160], entry[223:208]};
  assign entry_clus  = (clus_raw == 32'd0) ? CLUSTER_ROOT : clus_raw;
  assign entry_size  = entry[255:224];
  assign entry_isdir = ((attr & ATTR_ARCH) == 8'h00);
  assign sv_eff      = in_data.start_of_dir ? '0 : slot_valid_r;
  assign ended_eff   = in_data.start_of_dir ? 1'b0 : ended_r;

  always_comb begin
    for (int i = 0; i < SLOT_CHARS; i++) begin
      lfn_chars[8*i +: 8] = entry[8*NAME_POS[i] +: 8];
    end
  end

  fdep_sfn u_sfn (
    .entry (entry),
    .chars (sfn_chars)
  );

  always_comb begin
    rd_addr = '0;
    for (int i = NAME_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        rd_addr = SW'(i);
      end
    end
  end

  always_comb begin
    pend_clr          = pend_r;
    pend_clr[rd_addr] = 1'b0;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    slot_valid_nxt = slot_valid_r;
    ended_nxt      = ended_r;
    pend_nxt       = pend_r;
    last_nxt       = last_r;
    isdir_nxt      = isdir_r;
    clus_nxt       = clus_r;
    size_nxt       = size_r;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    load           = 1'b0;
    ld             = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          slot_valid_nxt = sv_eff;
          ended_nxt      = ended_eff;
          if (!ended_eff) begin
            if (first == MARK_END) begin
              ended_nxt           = 1'b1;
              load                = 1'b1;
              ld.end_of_directory = 1'b1;
              ld.last_of_run      = 1'b1;
            end else if (first == MARK_DELETED) begin
              ended_nxt = ended_eff;
            end else if (attr == ATTR_LFN) begin
              if (slot_ok) begin
                mem_we                  = 1'b1;
                slot_valid_nxt[wr_addr] = 1'b1;
              end
            end else if ((attr & (ATTR_DIR | ATTR_ARCH)) != 8'h00) begin
              if (sv_eff != '0) begin
                pend_nxt       = sv_eff;
                slot_valid_nxt = '0;
                isdir_nxt      = entry_isdir;
                clus_nxt       = entry_clus;
                size_nxt       = entry_size;
                state_nxt      = ST_READ;
              end else begin
                load             = 1'b1;
                ld               = make_chunk(sfn_chars);
                ld.is_directory  = entry_isdir;
                ld.start_cluster = entry_clus;
                ld.size_bytes    = entry_size;
                ld.last_of_run   = 1'b1;
              end
            end
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        pend_nxt  = pend_clr;
        last_nxt  = (pend_clr == '0);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          ld   = make_chunk(rd_data_r);
          if (last_r) begin
            ld.is_directory  = isdir_r;
            ld.start_cluster = clus_r;
            ld.size_bytes    = size_r;
            ld.last_of_run   = 1'b1;
            state_nxt        = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);
  assign out_data_nxt  = load ? ld : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      ended_r      <= 1'b0;
      pend_r       <= '0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      ended_r      <= ended_nxt;
      pend_r       <= pend_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    isdir_r    <= isdir_nxt;
    clus_r     <= clus_nxt;
    size_r     <= size_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= lfn_chars;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == ST_IDLE)
    else $error("Entry transaction taken during a name run.");

  a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> pend_r != '0)
    else $error("Slot read issued with no pending slot.");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_IDLE && pend_r == '0)
    else $error("Slot memory written during a name run.");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_free && last_r |=> state_r == ST_IDLE && out_data_r.last_of_run)
    else $error("Name run did not close with its last chunk.");

  a_slots_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> slot_valid_r == '0)
    else $error("Slot valid bits kept during a name run.");
`endif

endmodule
